>>> sv/random_fern_classifier_core_assert.svh
// Assertion macros for the random fern classifier core.
`ifndef RANDOM_FERN_CLASSIFIER_CORE_ASSERT_SVH
`define RANDOM_FERN_CLASSIFIER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RFC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RFC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RFC_ASSERT(label, clk, rst_n, prop, msg)
`define RFC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> sv/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared opcodes, register indexes and field widths of the fern classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rfc_pkg;
  typedef enum logic [1:0] {
    OP_LOAD_PIXEL = 2'd0,
    OP_LOAD_POINT = 2'd1,
    OP_LOAD_PROB  = 2'd2,
    OP_CLASSIFY   = 2'd3
  } opcode_e;

  localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] REG_FERNS       = 2'd1;
  localparam logic [1:0] REG_FEATURES    = 2'd2;
  localparam logic [1:0] REG_CLASSES     = 2'd3;

  // Store dimensions
  localparam int unsigned MaxFerns    = 16;
  localparam int unsigned MaxFeatures = 8;
  localparam int unsigned MaxClasses  = 16;
  localparam int unsigned MaxSide     = 64;

  localparam int unsigned PixW   = 16;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned ScoreW = 20;
  localparam int unsigned CoordW = 6;
  localparam int unsigned PointW = 4 * CoordW;

  localparam logic signed [ScoreW-1:0] ScoreMax = 20'sh7FFFF;
  localparam logic signed [ScoreW-1:0] ScoreMin = 20'sh80000;

  // Saturating add of one table entry into an accumulator.
  function automatic logic signed [ScoreW-1:0] sat_add(
    logic signed [ScoreW-1:0] acc, logic signed [ProbW-1:0] v);
    logic signed [ScoreW:0] s;
    s = {acc[ScoreW-1], acc} + {{(ScoreW+1-ProbW){v[ProbW-1]}}, v};
    if (s[ScoreW] != s[ScoreW-1]) begin
      return s[ScoreW] ? ScoreMin : ScoreMax;
    end
    return s[ScoreW-1:0];
  endfunction
endpackage

>>> sv/random_fern_classifier_core.sv
// ----------------------------------------------------------------------------
// random_fern_classifier_core
// Random-ferns inference: load stores, classify, emit one score per class.
// ----------------------------------------------------------------------------
// Usage: items enter on s_axis (tdata fields below, opcode in tuser). Load
// items (pixel, point pair, log-prob entry) are taken one per cycle while no
// classify is in progress and give no result. A classify item makes the block
// busy: it clears 16 accumulators (one per cycle), then for each fern walks
// each feature (point read, first and second pixel address, pixel reads,
// compare) through one address multiplier and one pixel comparator, forms
// the table address, then for each class reads the table and adds through
// one saturating adder on the table memory port. Scores then leave on
// m_axis one per cycle while the receiver is ready, class order, tlast on
// the final class.
// A stalled receiver holds the current score; nothing new is accepted until
// the last score is taken. Reset returns the sequencer to idle and the
// registers to their defaults; store contents are undefined until written.
// Configuration writes go through cfg_we_i/cfg_idx_i/cfg_data_i.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module random_fern_classifier_core import rfc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [6:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pixel_address[11:0], pixel_value[27:12], fern_number[31:28],
  // feature_number[34:32], first_row[40:35], first_col[46:41],
  // second_row[52:47], second_col[58:53], leaf_number[66:59],
  // load_class[70:67], log_prob[86:71], zero fill to 88
  input  logic [87:0]  s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // class_index[3:0], class_score[23:4]
  output logic [23:0]  m_axis_tdata,
  output logic         m_axis_tlast
);
  localparam int unsigned PixDepth = MaxSide * MaxSide;
  localparam int unsigned PtDepth  = MaxFerns * MaxFeatures;
  localparam int unsigned TabDepth = MaxFerns * (1 << MaxFeatures) * MaxClasses;
  localparam int unsigned FernW = $clog2(MaxFerns);
  localparam int unsigned FeatW = $clog2(MaxFeatures);
  localparam int unsigned ClsW  = $clog2(MaxClasses);
  localparam int unsigned PixAW = $clog2(PixDepth);
  localparam int unsigned PtAW  = FernW + FeatW;
  localparam int unsigned TabAW = FernW + MaxFeatures + ClsW;

  logic [6:0] width_q;
  logic [4:0] nf_q, nc_q;
  logic [3:0] nx_q;

  logic [PixW-1:0]   pix_mem [PixDepth];
  logic [PointW-1:0] pt_mem  [PtDepth];
  logic [ProbW-1:0]  tab_mem [TabDepth];
  logic [PixW-1:0]   pix_rd_q;
  logic [PointW-1:0] pt_rd_q;
  logic [ProbW-1:0]  tab_rd_q;

  logic [PixAW-1:0] pix_addr;
  logic [PtAW-1:0]  pt_addr;
  logic [TabAW-1:0] tab_addr;
  logic busy, acc_in;
  opcode_e op;
  logic signed [ScoreW-1:0] score;
  logic [ClsW-1:0] cls;

  assign op = opcode_e'(s_axis_tuser);
  assign s_axis_tready = !busy;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 7'd64; nf_q <= 5'd16; nx_q <= 4'd8; nc_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH: width_q <= cfg_data_i;
        REG_FERNS:       nf_q <= cfg_data_i[4:0];
        REG_FEATURES:    nx_q <= cfg_data_i[3:0];
        REG_CLASSES:     nc_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (acc_in && op == OP_LOAD_PIXEL)
      pix_mem[s_axis_tdata[11:0]] <= s_axis_tdata[27:12];
    pix_rd_q <= pix_mem[pix_addr];
  end
  // point word: first_row, first_col, second_row, second_col from the top
  always_ff @(posedge clk_i) begin
    if (acc_in && op == OP_LOAD_POINT)
      pt_mem[{s_axis_tdata[31:28], s_axis_tdata[34:32]}] <=
        {s_axis_tdata[40:35], s_axis_tdata[46:41], s_axis_tdata[52:47],
         s_axis_tdata[58:53]};
    pt_rd_q <= pt_mem[pt_addr];
  end
  always_ff @(posedge clk_i) begin
    if (acc_in && op == OP_LOAD_PROB)
      tab_mem[{s_axis_tdata[31:28], s_axis_tdata[66:59], s_axis_tdata[70:67]}] <=
        s_axis_tdata[86:71];
    tab_rd_q <= tab_mem[tab_addr];
  end

  rfc_seq #(.FernW(FernW), .FeatW(FeatW), .ClsW(ClsW), .PixAW(PixAW),
            .PtAW(PtAW), .TabAW(TabAW)) u_seq (
    .clk_i, .rst_ni,
    .start_i(acc_in && op == OP_CLASSIFY),
    .width_i(width_q), .nf_i(nf_q), .nx_i(nx_q), .nc_i(nc_q),
    .pt_addr_o(pt_addr), .pt_data_i(pt_rd_q),
    .pix_addr_o(pix_addr), .pix_data_i(pix_rd_q),
    .tab_addr_o(tab_addr), .tab_data_i(tab_rd_q),
    .busy_o(busy),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_cls_o(cls), .out_score_o(score), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {score, cls};
endmodule

>>> sv/rfc_seq.sv
// ----------------------------------------------------------------------------
// rfc_seq
// Classify sequencer: walks features, ferns and classes through one pixel
// compare, one address multiplier and one saturating adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "random_fern_classifier_core_assert.svh"
module rfc_seq import rfc_pkg::*; #(
  parameter int unsigned FernW = 4,
  parameter int unsigned FeatW = 3,
  parameter int unsigned ClsW  = 4,
  parameter int unsigned PixAW = 12,
  parameter int unsigned PtAW  = 7,
  parameter int unsigned TabAW = 16,
  parameter int unsigned NFernW = 5,
  parameter int unsigned NFeatW = 4,
  parameter int unsigned NClsW  = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [6:0]              width_i,
  input  logic [NFernW-1:0]       nf_i,
  input  logic [NFeatW-1:0]       nx_i,
  input  logic [NClsW-1:0]        nc_i,
  output logic [PtAW-1:0]         pt_addr_o,
  input  logic [PointW-1:0]       pt_data_i,
  output logic [PixAW-1:0]        pix_addr_o,
  input  logic [PixW-1:0]         pix_data_i,
  output logic [TabAW-1:0]        tab_addr_o,
  input  logic signed [ProbW-1:0] tab_data_i,
  output logic                    busy_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ClsW-1:0]         out_cls_o,
  output logic signed [ScoreW-1:0] out_score_o,
  output logic                    out_last_o
);
  localparam int unsigned MaxClasses = 1 << ClsW;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_PT, S_PA, S_PAW, S_PB, S_PBW, S_CMP,
    S_TREQ, S_TWAIT, S_ACC, S_EMIT
  } state_e;

  state_e state_q;
  logic [FernW-1:0] fern_q;
  logic [FeatW-1:0] feat_q;
  logic [ClsW-1:0] cls_q;
  logic [NFernW-1:0] nf_q;
  logic [NFeatW-1:0] nx_q;
  logic [NClsW-1:0] nc_q;
  logic [7:0] leaf_q;
  logic [PointW-1:0] pt_q;
  logic [PixW-1:0] pa_q;
  logic [PixAW-1:0] pix_addr_q;
  logic [TabAW-1:0] tab_addr_q;
  logic signed [ScoreW-1:0] acc_q [MaxClasses];
  logic out_valid_q;
  logic [CoordW-1:0] row_sel, col_sel;
  logic [CoordW+7-1:0] lin;

  // Shared address unit: row*width + col, first pixel in S_PAW, second in S_PB.
  always_comb begin
    row_sel = (state_q == S_PAW) ? pt_q[4*CoordW-1:3*CoordW] : pt_q[2*CoordW-1:CoordW];
    col_sel = (state_q == S_PAW) ? pt_q[3*CoordW-1:2*CoordW] : pt_q[CoordW-1:0];
    lin = {7'd0, row_sel} * {6'd0, width_i} + {7'd0, col_sel};
  end

  assign pt_addr_o   = PtAW'({fern_q, feat_q});
  assign pix_addr_o  = pix_addr_q;
  assign tab_addr_o  = tab_addr_q;
  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_cls_o   = cls_q;
  assign out_score_o = acc_q[cls_q];
  assign out_last_o  = ({1'b0, cls_q} == NClsW'(nc_q - 1'b1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      fern_q <= '0; feat_q <= '0; cls_q <= '0;
      nf_q <= '0; nx_q <= '0; nc_q <= '0; leaf_q <= '0;
      pt_q <= '0; pa_q <= '0; pix_addr_q <= '0; tab_addr_q <= '0;
      for (int i = 0; i < MaxClasses; i++) acc_q[i] <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            nf_q <= (nf_i > NFernW'(1 << FernW)) ? NFernW'(1 << FernW) : nf_i;
            nx_q <= (nx_i > NFeatW'(1 << FeatW)) ? NFeatW'(1 << FeatW) : nx_i;
            nc_q <= (nc_i > NClsW'(MaxClasses)) ? NClsW'(MaxClasses) :
                    (nc_i == '0) ? NClsW'(1) : nc_i;
            cls_q <= '0;
            state_q <= S_CLEAR;
          end
        end
        // clear one accumulator per cycle
        S_CLEAR: begin
          acc_q[cls_q] <= '0;
          if (cls_q == ClsW'(MaxClasses - 1)) begin
            cls_q <= '0; fern_q <= '0; feat_q <= '0; leaf_q <= '0;
            state_q <= (nf_q == '0) ? S_EMIT : S_PT;
            out_valid_q <= (nf_q == '0);
          end else cls_q <= cls_q + 1'b1;
        end
        // point address is presented here, read data lands for S_PA
        S_PT: begin
          if ({1'b0, feat_q} == NFeatW'(nx_q)) state_q <= S_TREQ;
          else state_q <= S_PA;
        end
        S_PA: begin
          pt_q <= pt_data_i;
          state_q <= S_PAW;
        end
        S_PAW: begin
          pix_addr_q <= lin[PixAW-1:0];
          state_q <= S_PB;
        end
        S_PB: begin
          pix_addr_q <= lin[PixAW-1:0];
          state_q <= S_PBW;
        end
        S_PBW: begin
          pa_q <= pix_data_i;
          state_q <= S_CMP;
        end
        // second pixel is on the read port, shift the compare bit into the leaf
        S_CMP: begin
          leaf_q <= {leaf_q[6:0], (pa_q < pix_data_i)};
          feat_q <= feat_q + 1'b1;
          state_q <= ({1'b0, feat_q} + 1'b1 == NFeatW'(nx_q)) ? S_TREQ : S_PT;
        end
        S_TREQ: begin
          tab_addr_q <= TabAW'({fern_q, leaf_q, cls_q});
          state_q <= S_TWAIT;
        end
        S_TWAIT: state_q <= S_ACC;
        // one saturating add per class, one class at a time; S_TWAIT waits for each table read
        S_ACC: begin
          acc_q[cls_q] <= sat_add(acc_q[cls_q], tab_data_i);
          if ({1'b0, cls_q} + 1'b1 == NClsW'(nc_q)) begin
            cls_q <= '0;
            if ({1'b0, fern_q} + 1'b1 == NFernW'(nf_q)) begin
              state_q <= S_EMIT; out_valid_q <= 1'b1;
            end else begin
              fern_q <= fern_q + 1'b1; feat_q <= '0; leaf_q <= '0;
              state_q <= S_PT;
            end
          end else begin
            cls_q <= cls_q + 1'b1;
            tab_addr_q <= tab_addr_q + 1'b1;
            state_q <= S_TWAIT;
          end
        end
        S_EMIT: begin
          if (out_ready_i) begin
            if (out_last_o) begin
              out_valid_q <= 1'b0; cls_q <= '0; state_q <= S_IDLE;
            end else cls_q <= cls_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `RFC_ASSERT(a_valid_emit, clk_i, rst_ni, out_valid_q == (state_q == S_EMIT), "valid outside emit")
  `RFC_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, out_valid_q && out_ready_i && out_last_o, state_q == S_IDLE, "no idle")
  `RFC_ASSERT(a_no_start_busy, clk_i, rst_ni, !(start_i && busy_o), "start while busy")
endmodule
